### hdl/dq_pkg.sv
// shared types and codes for the double-ended queue
// request codes, status codes and the per-cell operation struct
// no dependencies
`default_nettype none

package dq_pkg;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned WORD_W = 32;

  // request codes carried in the input tuser
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_ALL   = 3'd4;

  // status codes carried in the output tuser
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // operation broadcast to every cell of the chain, at most one bit set
  typedef struct packed {
    logic push_front;  // shift toward the back, new word at the front
    logic push_back;   // first free cell takes the new word
    logic pop_front;   // shift toward the front
    logic pop_back;    // tail cell drops out
    logic rotate;      // front word wraps to the tail, rest shift forward
  } cell_op_t;

endpackage

`default_nettype wire

### hdl/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words, built as a chain of cells.
// Input channel s_*: s_tuser[2:0] request (push front, push back, pop front,
// pop back, read all), s_tdata[31:0] word to push. Output channel m_*:
// m_tdata[31:0] popped or read word, m_tuser[1:0] status (ok, empty, full),
// m_tlast on the final result of a request.
// The front word always sits in the first cell; a front push or pop shifts the
// whole chain and a back push or pop only its tail; the single result of a
// push or pop appears in the output register the cycle after the transfer.
// A read-all rotates the chain once per stored entry: it gives one result per
// cycle while the receiver does not stall, as many as the fill count (1 to DEPTH),
// the first loaded by the read state that follows the transfer, and leaves the
// order as it was; no request is taken until its last result has been loaded.
// Unused request codes are taken and give no result.
// When the receiver stalls, the result waits in the output register and the
// input is held off until that register is free or drained in the same cycle.
// Reset clears the valid bits of all cells, the fill count and the output
// valid; stored words are not cleared and are never read before being written.
// Depends on dq_pkg and dq_cell.
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // [31:0] value
  input  wire logic [2:0]  s_tuser,  // [2:0] req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // [31:0] value_res
  output logic [1:0]       m_tuser,  // [1:0] status
  output logic             m_tlast
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned W  = dq_pkg::WORD_W;

  typedef enum logic {ST_IDLE, ST_READ} state_t;

  state_t           state;
  state_t           state_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [CW-1:0]    remaining;
  logic [CW-1:0]    remaining_next;
  dq_pkg::cell_op_t op;

  logic                      m_tvalid_next;
  logic [W-1:0]              m_tdata_next;
  logic [dq_pkg::STAT_W-1:0] m_tuser_next;
  logic                      m_tlast_next;

  logic [DEPTH-1:0] cell_valid;
  logic [W-1:0]     cell_data [DEPTH];
  logic [W-1:0]     cell_tail [DEPTH];
  logic [W-1:0]     tail_word;

  logic out_free;
  logic take;
  logic full;
  logic empty;

  assign out_free = ~m_tvalid | m_tready;
  assign s_tready = (state == ST_IDLE) & out_free;
  assign take     = s_tvalid & s_tready;
  assign full     = cell_valid[DEPTH-1];
  assign empty    = ~cell_valid[0];

  // word of the tail cell, all other cells give zero
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_word = tail_word | cell_tail[i];
    end
  end

  // operation for the chain in this cycle
  always_comb begin
    op = '0;
    if (take) begin
      unique case (s_tuser)
        dq_pkg::REQ_PUSH_FRONT: op.push_front = ~full;
        dq_pkg::REQ_PUSH_BACK:  op.push_back  = ~full;
        dq_pkg::REQ_POP_FRONT:  op.pop_front  = ~empty;
        dq_pkg::REQ_POP_BACK:   op.pop_back   = ~empty;
        default: ;
      endcase
    end else if (state == ST_READ && out_free) begin
      op.rotate = 1'b1;
    end
  end

  // chain of cells, front word in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic         pv;
    logic [W-1:0] pd;
    logic         nv;
    logic [W-1:0] nd;

    if (i == 0) begin : g_first
      assign pv = 1'b1;
      assign pd = s_tdata;
    end else begin : g_mid
      assign pv = cell_valid[i-1];
      assign pd = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign nv = 1'b0;
      assign nd = '0;
    end else begin : g_inner
      assign nv = cell_valid[i+1];
      assign nd = cell_data[i+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .push_value (s_tdata),
      .prev_valid (pv),
      .prev_data  (pd),
      .next_valid (nv),
      .next_data  (nd),
      .head_data  (cell_data[0]),
      .valid      (cell_valid[i]),
      .data       (cell_data[i]),
      .tail_data  (cell_tail[i])
    );
  end

  // request sequencing, fill count and next output register contents
  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    m_tvalid_next  = m_tvalid & ~m_tready;
    m_tdata_next   = m_tdata;
    m_tuser_next   = m_tuser;
    m_tlast_next   = m_tlast;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = '0;
          m_tuser_next  = dq_pkg::STAT_OK;
          m_tlast_next  = 1'b1;
          unique case (s_tuser)
            dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: begin
              if (full) begin
                m_tuser_next = dq_pkg::STAT_FULL;
              end else begin
                count_next = count + CW'(1);
              end
            end
            dq_pkg::REQ_POP_FRONT: begin
              if (empty) begin
                m_tuser_next = dq_pkg::STAT_EMPTY;
              end else begin
                m_tdata_next = cell_data[0];
                count_next   = count - CW'(1);
              end
            end
            dq_pkg::REQ_POP_BACK: begin
              if (empty) begin
                m_tuser_next = dq_pkg::STAT_EMPTY;
              end else begin
                m_tdata_next = tail_word;
                count_next   = count - CW'(1);
              end
            end
            dq_pkg::REQ_READ_ALL: begin
              if (empty) begin
                m_tuser_next = dq_pkg::STAT_EMPTY;
              end else begin
                m_tvalid_next  = 1'b0;
                remaining_next = count;
                state_next     = ST_READ;
              end
            end
            default: begin
              m_tvalid_next = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          m_tvalid_next  = 1'b1;
          m_tdata_next   = cell_data[0];
          m_tuser_next   = dq_pkg::STAT_OK;
          m_tlast_next   = (remaining == CW'(1));
          remaining_next = remaining - CW'(1);
          if (remaining == CW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remaining <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      m_tvalid  <= m_tvalid_next;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    m_tdata <= m_tdata_next;
    m_tuser <= m_tuser_next;
    m_tlast <= m_tlast_next;
  end

endmodule

`default_nettype wire

### hdl/dq_cell.sv
// one storage cell of the queue chain
// holds a word and a valid bit, trades data with its two neighbors
// depends on dq_pkg
`default_nettype none

module dq_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire dq_pkg::cell_op_t          op,
  input  wire logic [dq_pkg::WORD_W-1:0] push_value,
  input  wire logic                      prev_valid,
  input  wire logic [dq_pkg::WORD_W-1:0] prev_data,
  input  wire logic                      next_valid,
  input  wire logic [dq_pkg::WORD_W-1:0] next_data,
  input  wire logic [dq_pkg::WORD_W-1:0] head_data,
  output logic                           valid,
  output logic [dq_pkg::WORD_W-1:0]      data,
  output logic [dq_pkg::WORD_W-1:0]      tail_data
);

  logic                      is_tail;
  logic                      valid_next;
  logic [dq_pkg::WORD_W-1:0] data_next;

  // last occupied cell of the chain
  assign is_tail   = valid & ~next_valid;
  assign tail_data = is_tail ? data : '0;

  // next valid bit and word for each operation
  always_comb begin
    valid_next = valid;
    data_next  = data;
    priority if (op.push_front) begin
      valid_next = prev_valid;
      data_next  = prev_data;
    end else if (op.push_back) begin
      valid_next = prev_valid;
      if (prev_valid & ~valid) begin
        data_next = push_value;
      end
    end else if (op.pop_front) begin
      valid_next = next_valid;
      data_next  = next_data;
    end else if (op.pop_back) begin
      valid_next = next_valid;
    end else if (op.rotate) begin
      data_next = is_tail ? head_data : next_data;
    end else begin
      // no operation, cell holds
      valid_next = valid;
      data_next  = data;
    end
  end

  // valid bit is control, word is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

### hdl/dq_checker.sv
// port-level checks for the double-ended queue
// bound to double_ended_queue, uses dq_pkg status codes
`default_nettype none

module dq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // empty and full reports are single results
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != dq_pkg::STAT_OK |-> m_tlast)
    else $error("error report without last");

  // empty and full reports carry a zero word
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != dq_pkg::STAT_OK |-> m_tdata == 32'd0)
    else $error("error report with nonzero word");

  // a read-out in progress keeps the input closed
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !(s_tvalid && s_tready))
    else $error("transfer accepted during read-out");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/tb.sv
// self-checking testbench for the double_ended_queue block
// predicts every result from its own circular-buffer deque and checks the m_* stream
// depends on dq_pkg and the double_ended_queue rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned MAX_REPORTS = 10;

  // request codes the block takes and ignores
  localparam logic [dq_pkg::REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [dq_pkg::REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;

  typedef struct {
    logic signed [dq_pkg::WORD_W-1:0] value_res;
    logic [dq_pkg::STAT_W-1:0]        status;
    logic                             last;
  } deque_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata = '0;  // [31:0] value
  logic [2:0]        s_tuser = '0;  // [2:0] req_type
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;       // [31:0] value_res
  logic [1:0]        m_tuser;       // [1:0] status
  logic              m_tlast;

  // predicted deque contents
  logic signed [dq_pkg::WORD_W-1:0] model_slot [DEPTH];
  int unsigned                      model_head  = 0;
  int unsigned                      model_count = 0;

  deque_result_t pending_results[$];

  int          send_idle   = 0;
  int          recv_stall  = 0;
  int unsigned hold_left   = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  double_ended_queue #(.DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // add one predicted result to the store
  task automatic expect_result(input logic signed [dq_pkg::WORD_W-1:0] word,
                               input logic [dq_pkg::STAT_W-1:0] status,
                               input logic last);
    deque_result_t r;
    r.value_res = word;
    r.status    = status;
    r.last      = last;
    pending_results.push_back(r);
  endtask

  // deque predictor, run once per accepted request
  task automatic predict_request(input logic [dq_pkg::REQ_W-1:0] req,
                                 input logic signed [dq_pkg::WORD_W-1:0] word);
    int unsigned slot;
    case (req)
      dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: begin
        if (model_count >= DEPTH) begin
          expect_result('0, dq_pkg::STAT_FULL, 1'b1);
        end else begin
          if (req == dq_pkg::REQ_PUSH_FRONT) begin
            model_head = (model_head == 0) ? DEPTH - 1 : model_head - 1;
            model_slot[model_head] = word;
          end else begin
            model_slot[(model_head + model_count) % DEPTH] = word;
          end
          model_count++;
          expect_result('0, dq_pkg::STAT_OK, 1'b1);
        end
      end
      dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK: begin
        if (model_count == 0) begin
          expect_result('0, dq_pkg::STAT_EMPTY, 1'b1);
        end else begin
          if (req == dq_pkg::REQ_POP_FRONT) begin
            slot = model_head;
            model_head = (model_head + 1) % DEPTH;
          end else begin
            slot = (model_head + model_count - 1) % DEPTH;
          end
          model_count--;
          expect_result(model_slot[slot], dq_pkg::STAT_OK, 1'b1);
        end
      end
      dq_pkg::REQ_READ_ALL: begin
        if (model_count == 0) begin
          expect_result('0, dq_pkg::STAT_EMPTY, 1'b1);
        end else begin
          for (int unsigned i = 0; i < model_count; i++) begin
            expect_result(model_slot[(model_head + i) % DEPTH], dq_pkg::STAT_OK,
                          (i + 1 == model_count));
          end
        end
      end
      default: begin
        // unused codes: no result, no change
      end
    endcase
  endtask

  // one request transfer, with random sender idling in front of it
  task automatic send_request(input logic [dq_pkg::REQ_W-1:0] req,
                              input logic [31:0] word);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = req;
    s_tdata  = word;
    do @(posedge clk); while (!s_tready);
    predict_request(req, word);
  endtask

  // random request, pushes weighted by push_bias percent
  task automatic send_random(input int push_bias);
    int                       roll;
    int unsigned              pick;
    logic [dq_pkg::REQ_W-1:0] code;
    roll = $urandom_range(99);
    pick = $urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST);
    code = pick[dq_pkg::REQ_W-1:0];
    if (roll < 4) begin
      send_request(code, $urandom());
    end else if (roll < 12) begin
      send_request(dq_pkg::REQ_READ_ALL, $urandom());
    end else if ($urandom_range(99) < push_bias) begin
      send_request($urandom_range(1) ? dq_pkg::REQ_PUSH_BACK : dq_pkg::REQ_PUSH_FRONT,
                   $urandom());
    end else begin
      send_request($urandom_range(1) ? dq_pkg::REQ_POP_BACK : dq_pkg::REQ_POP_FRONT,
                   $urandom());
    end
  endtask

  // empty-queue reports, word extremes, unused codes, pops at both ends
  task automatic test_directed();
    send_request(dq_pkg::REQ_POP_FRONT, $urandom());
    send_request(dq_pkg::REQ_POP_BACK, $urandom());
    send_request(dq_pkg::REQ_READ_ALL, $urandom());
    send_request(dq_pkg::REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    send_request(dq_pkg::REQ_PUSH_BACK, 32'h8000_0000);
    send_request(dq_pkg::REQ_PUSH_FRONT, 32'h0000_0000);
    send_request(dq_pkg::REQ_PUSH_BACK, 32'hFFFF_FFFF);
    send_request(dq_pkg::REQ_READ_ALL, $urandom());
    send_request(REQ_UNUSED_FIRST, $urandom());
    send_request(REQ_UNUSED_FIRST + 3'd1, $urandom());
    send_request(REQ_UNUSED_LAST, $urandom());
    send_request(dq_pkg::REQ_POP_FRONT, $urandom());
    send_request(dq_pkg::REQ_POP_BACK, $urandom());
    send_request(dq_pkg::REQ_READ_ALL, $urandom());
    send_request(dq_pkg::REQ_POP_FRONT, $urandom());
    send_request(dq_pkg::REQ_POP_BACK, $urandom());
    send_request(dq_pkg::REQ_POP_BACK, $urandom());
    send_request(dq_pkg::REQ_READ_ALL, $urandom());
    send_request(dq_pkg::REQ_PUSH_BACK, $urandom());
    send_request(dq_pkg::REQ_POP_BACK, $urandom());
  endtask

  // fill to capacity, push onto full, read out, drain past empty
  task automatic test_fill_drain();
    while (model_count < DEPTH) begin
      send_request($urandom_range(1) ? dq_pkg::REQ_PUSH_BACK : dq_pkg::REQ_PUSH_FRONT,
                   $urandom());
    end
    send_request(dq_pkg::REQ_PUSH_FRONT, $urandom());
    send_request(dq_pkg::REQ_PUSH_BACK, $urandom());
    send_request(dq_pkg::REQ_READ_ALL, $urandom());
    while (model_count > 0) begin
      send_request($urandom_range(1) ? dq_pkg::REQ_POP_BACK : dq_pkg::REQ_POP_FRONT,
                   $urandom());
    end
    send_request(dq_pkg::REQ_POP_FRONT, $urandom());
    send_request(dq_pkg::REQ_READ_ALL, $urandom());
  endtask

  // receiver holds off a long stretch so the block backs up its input
  task automatic test_backpressure();
    hold_left = 300;
    for (int i = 0; i < 20; i++) begin
      send_random(60);
    end
  endtask

  // random walk of the fill level, bias redrawn every 30 requests
  task automatic test_random(input int n);
    int push_bias;
    push_bias = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 30 == 0) push_bias = 25 + 25 * $urandom_range(2);
      send_random(push_bias);
    end
  endtask

  // receiver ready, with random stalls and the long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        m_tready  = 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_tready = ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // result checker against the oldest prediction
  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: value %0d status %0d last %0b",
                   $signed(m_tdata), m_tuser, m_tlast);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.value_res || m_tuser !== want.status ||
            m_tlast !== want.last) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: expected value %0d status %0d last %0b, got %0d %0d %0b",
                     want.value_res, want.status, want.last,
                     $signed(m_tdata), m_tuser, m_tlast);
        end
      end
    end
  end

  // cycle limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // test sequence
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle = 0;  recv_stall = 0;
    test_directed();
    test_random(90);

    send_idle = 49; recv_stall = 0;
    test_random(90);
    test_backpressure();

    send_idle = 0;  recv_stall = 49;
    test_random(90);

    send_idle = 8;  recv_stall = 8;
    test_fill_drain();
    test_random(90);

    @(negedge clk);
    s_tvalid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/dq_pkg.sv
hdl/dq_cell.sv
hdl/double_ended_queue.sv
hdl/dq_checker.sv
tb/tb.sv
